/* rtl/lpcf_pkg.sv */
// Shared types and constants for the lexicon prefix cohort filter.
// No dependencies.
package lpcf_pkg;

    localparam int LEXICON_DEPTH    = 1024;
    localparam int MAX_WORD_SYMBOLS = 16;
    localparam int MAX_COHORT       = 64;
    localparam int IDX_W            = $clog2(LEXICON_DEPTH);
    localparam int POS_W            = $clog2(MAX_WORD_SYMBOLS);
    localparam int LEN_W            = 5;
    localparam int CNT_W            = 11;
    localparam int COH_W            = 7;
    localparam int SYM_W            = 8;
    localparam int WORD_W           = 32;
    localparam int CONF_W           = 16;
    localparam int CFG_W            = 11;
    localparam int QDEPTH           = 4;
    localparam int QPTR_W           = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        K_HEADER = 2'd0,
        K_SYMBOL = 2'd1,
        K_PUSH   = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        R_LEXICON_COUNT  = 2'd0,
        R_COHORT_LIMIT   = 2'd1,
        R_SEQUENCE_LIMIT = 2'd2,
        R_UNUSED         = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_kind                 kind;
        logic [IDX_W-1:0]      idx;
        logic [POS_W-1:0]      pos;
        logic [SYM_W-1:0]      sym;
        logic [WORD_W-1:0]     word;
        logic [LEN_W-1:0]      wlen;
        logic [CONF_W-1:0]     conf;
        logic [LEN_W-1:0]      cap;
        logic [CNT_W-1:0]      scan;
        logic [COH_W-1:0]      lim;
    } t_job;

endpackage

/* rtl/lexicon_prefix_cohort_filter.sv */
// Top level of the lexicon prefix cohort filter: config registers, front, back.
// Depends on lpcf_pkg, lpcf_front and lpcf_back.
//
// channel   signals                                   handshake
// in        i_kind .. i_confidence                    i_start && !o_busy
// out       o_match_word .. o_last_result             o_strobe, one cycle
// cfg       i_cfg_we, i_cfg_index, i_cfg_data         i_cfg_we
//
// A load or sequence clear gives its single result from the S_FINISH state.
// A push scans up to lexicon_count entries one per cycle from one lexicon
// memory read port, stopping early when the cohort limit is reached.
// Up to three items queue between front and back; o_busy holds while full.
// Reset is synchronous; no clearing pass. Results cannot be stalled.
module lexicon_prefix_cohort_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_kind,
    input  logic [lpcf_pkg::IDX_W-1:0]        i_entry_index,
    input  logic [lpcf_pkg::POS_W-1:0]        i_symbol_position,
    input  logic [lpcf_pkg::SYM_W-1:0]        i_symbol,
    input  logic [lpcf_pkg::WORD_W-1:0]       i_word_ident,
    input  logic [lpcf_pkg::LEN_W-1:0]        i_word_length,
    input  logic [lpcf_pkg::CONF_W-1:0]       i_confidence,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [lpcf_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                              o_strobe,
    output logic [lpcf_pkg::WORD_W-1:0]       o_match_word,
    output logic [lpcf_pkg::LEN_W-1:0]        o_matched_count,
    output logic [lpcf_pkg::CONF_W-1:0]       o_match_confidence,
    output logic                              o_word_complete,
    output logic                              o_match_valid,
    output logic                              o_last_result
);
    import lpcf_pkg::*;

    logic [CNT_W-1:0]   r_lexicon_count;
    logic [COH_W-1:0]   r_cohort_limit;
    logic [LEN_W-1:0]   r_sequence_limit;
    logic               full, take, q_valid, q_pop;
    t_job               q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lexicon_count  <= '0;
            r_cohort_limit   <= COH_W'(64);
            r_sequence_limit <= LEN_W'(16);
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                R_LEXICON_COUNT:  r_lexicon_count  <= i_cfg_data[CNT_W-1:0];
                R_COHORT_LIMIT:   r_cohort_limit   <= i_cfg_data[COH_W-1:0];
                R_SEQUENCE_LIMIT: r_sequence_limit <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_busy = full;
    assign take   = i_start && !full;

    lpcf_front u_front (
        .i_clk, .i_rst_n,
        .i_take            (take),
        .i_kind, .i_entry_index, .i_symbol_position, .i_symbol,
        .i_word_ident, .i_word_length, .i_confidence,
        .i_lexicon_count   (r_lexicon_count),
        .i_cohort_limit    (r_cohort_limit),
        .i_sequence_limit  (r_sequence_limit),
        .o_full            (full),
        .o_q_valid         (q_valid),
        .o_q_job           (q_job),
        .i_q_pop           (q_pop)
    );

    lpcf_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid         (q_valid),
        .i_q_job           (q_job),
        .o_q_pop           (q_pop),
        .o_strobe, .o_match_word, .o_matched_count, .o_match_confidence,
        .o_word_complete, .o_match_valid, .o_last_result
    );
endmodule

/* rtl/lpcf_front.sv */
// Front end: accepts items, clamps the register settings, queues jobs.
// Depends on lpcf_pkg.
module lpcf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  logic [1:0]                        i_kind,
    input  logic [lpcf_pkg::IDX_W-1:0]        i_entry_index,
    input  logic [lpcf_pkg::POS_W-1:0]        i_symbol_position,
    input  logic [lpcf_pkg::SYM_W-1:0]        i_symbol,
    input  logic [lpcf_pkg::WORD_W-1:0]       i_word_ident,
    input  logic [lpcf_pkg::LEN_W-1:0]        i_word_length,
    input  logic [lpcf_pkg::CONF_W-1:0]       i_confidence,
    input  logic [lpcf_pkg::CNT_W-1:0]        i_lexicon_count,
    input  logic [lpcf_pkg::COH_W-1:0]        i_cohort_limit,
    input  logic [lpcf_pkg::LEN_W-1:0]        i_sequence_limit,
    output logic                              o_full,
    output logic                              o_q_valid,
    output lpcf_pkg::t_job                    o_q_job,
    input  logic                              i_q_pop
);
    import lpcf_pkg::*;

    t_job                  r_q [QDEPTH];
    logic [QPTR_W-1:0]     r_wr, r_rd;
    logic [QPTR_W:0]       r_cnt;
    t_job                  job;
    logic                  push;

    always_comb begin
        job.kind = t_kind'(i_kind);
        job.idx  = i_entry_index;
        job.pos  = i_symbol_position;
        job.sym  = i_symbol;
        job.word = i_word_ident;
        job.wlen = i_word_length;
        job.conf = i_confidence;
        job.cap  = (i_sequence_limit > LEN_W'(MAX_WORD_SYMBOLS)) ?
                   LEN_W'(MAX_WORD_SYMBOLS) : i_sequence_limit;
        job.scan = (i_lexicon_count > CNT_W'(LEXICON_DEPTH)) ?
                   CNT_W'(LEXICON_DEPTH) : i_lexicon_count;
        job.lim  = (i_cohort_limit > COH_W'(MAX_COHORT)) ?
                   COH_W'(MAX_COHORT) : i_cohort_limit;
    end

    assign push = i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_q_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(push) - (QPTR_W+1)'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= job;
        end
    end

    assign o_full     = (r_cnt >= (QPTR_W+1)'(QDEPTH - 1));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_job    = r_q[r_rd];
endmodule

/* rtl/lpcf_back.sv */
// Back end: holds the lexicon memories and heard sequence, carries out each
// job in order and scans one entry per cycle. Depends on lpcf_pkg.
module lpcf_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  lpcf_pkg::t_job                    i_q_job,
    output logic                              o_q_pop,
    output logic                              o_strobe,
    output logic [lpcf_pkg::WORD_W-1:0]       o_match_word,
    output logic [lpcf_pkg::LEN_W-1:0]        o_matched_count,
    output logic [lpcf_pkg::CONF_W-1:0]       o_match_confidence,
    output logic                              o_word_complete,
    output logic                              o_match_valid,
    output logic                              o_last_result
);
    import lpcf_pkg::*;

    localparam int ROW_W = SYM_W * MAX_WORD_SYMBOLS;

    logic [WORD_W-1:0]  mem_word [LEXICON_DEPTH];
    logic [LEN_W-1:0]   mem_len  [LEXICON_DEPTH];
    logic [ROW_W-1:0]   mem_sym  [LEXICON_DEPTH];

    t_state             r_state, n_state;
    t_job               r_job;
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic [COH_W-1:0]   r_found, n_found;
    logic               r_rd_v, n_rd_v;
    logic [WORD_W-1:0]  r_rd_word;
    logic [LEN_W-1:0]   r_rd_len;
    logic [ROW_W-1:0]   r_rd_row;
    logic               r_pend, n_pend;
    logic [WORD_W-1:0]  r_pw;
    logic               r_pc;
    logic               r_strobe, n_strobe;
    logic [WORD_W-1:0]  r_ow;
    logic [LEN_W-1:0]   r_oc;
    logic [CONF_W-1:0]  r_of;
    logic               r_ocmp, r_ov, r_ol;
    logic               n_ov, n_ol;
    logic               hit, rd_en, load;
    logic [MAX_WORD_SYMBOLS-1:0] eq;
    logic [IDX_W-1:0]   rd_idx;
    logic [LEN_W-1:0]   r_hlen;
    logic [SYM_W-1:0]   r_heard [MAX_WORD_SYMBOLS];
    logic               hdr_we, sym_we, clr, append;

    assign hdr_we = (r_state == S_IDLE) && i_q_valid && (i_q_job.kind == K_HEADER);
    assign sym_we = (r_state == S_IDLE) && i_q_valid && (i_q_job.kind == K_SYMBOL);
    assign clr    = (r_state == S_IDLE) && i_q_valid && (i_q_job.kind == K_CLEAR);
    assign append = (r_state == S_IDLE) && i_q_valid && (i_q_job.kind == K_PUSH) &&
                    (r_hlen < i_q_job.cap);

    // per-symbol compare against the heard prefix
    always_comb begin
        for (int p = 0; p < MAX_WORD_SYMBOLS; p++) begin
            eq[p] = (r_rd_row[p*SYM_W +: SYM_W] == r_heard[p]) ||
                    (LEN_W'(p) >= r_hlen);
        end
        hit = r_rd_v && (r_hlen <= r_rd_len) && (&eq);
    end

    assign rd_idx = r_addr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            mem_word[i_q_job.idx] <= i_q_job.word;
            mem_len[i_q_job.idx]  <= i_q_job.wlen;
        end
        if (sym_we) begin
            mem_sym[i_q_job.idx][i_q_job.pos*SYM_W +: SYM_W] <= i_q_job.sym;
        end
        if (rd_en) begin
            r_rd_word <= mem_word[rd_idx];
            r_rd_len  <= mem_len[rd_idx];
            r_rd_row  <= mem_sym[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (append) begin
            r_heard[r_hlen[POS_W-1:0]] <= i_q_job.sym;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_found  = r_found;
        n_rd_v   = 1'b0;
        n_pend   = r_pend;
        n_strobe = 1'b0;
        n_ov     = 1'b0;
        n_ol     = 1'b0;
        rd_en    = 1'b0;
        o_q_pop  = 1'b0;
        load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    load    = 1'b1;
                    n_addr  = '0;
                    n_found = '0;
                    n_pend  = 1'b0;
                    if (i_q_job.kind == K_PUSH && i_q_job.scan != '0 &&
                        i_q_job.lim != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                // issue a read; a new hit emits the previously held hit and takes its place
                if (hit) begin
                    if (r_pend) begin
                        n_strobe = 1'b1;
                        n_ov     = 1'b1;
                    end
                    n_pend  = 1'b1;
                    n_found = r_found + COH_W'(1);
                end
                if (hit && (r_found + COH_W'(1) == r_job.lim)) begin
                    n_state = S_DRAIN;
                end else if (r_addr == r_job.scan) begin
                    n_state = (r_rd_v) ? S_SCAN : S_DRAIN;
                    if (!r_rd_v) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    rd_en  = 1'b1;
                    n_rd_v = 1'b1;
                    n_addr = r_addr + CNT_W'(1);
                end
            end
            S_DRAIN: begin
                n_strobe = 1'b1;
                n_ov     = r_pend;
                n_ol     = 1'b1;
                n_pend   = 1'b0;
                n_state  = S_IDLE;
            end
            S_FINISH: begin
                n_strobe = 1'b1;
                n_ol     = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_v   <= 1'b0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
            r_addr   <= '0;
            r_found  <= '0;
            r_hlen   <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_v   <= n_rd_v;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
            r_addr   <= n_addr;
            r_found  <= n_found;
            if (clr) begin
                r_hlen <= '0;
            end else if (append) begin
                r_hlen <= r_hlen + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end
        if (hit) begin
            r_pw <= r_rd_word;
            r_pc <= (r_hlen == r_rd_len);
        end
        r_ov <= n_ov;
        r_ol <= n_ol;
        if (n_ov) begin
            r_ow   <= r_pw;
            r_oc   <= r_hlen;
            r_of   <= r_job.conf;
            r_ocmp <= r_pc;
        end
    end

    assign o_strobe           = r_strobe;
    assign o_match_valid      = r_ov;
    assign o_last_result      = r_ol;
    assign o_match_word       = r_ov ? r_ow : '0;
    assign o_matched_count    = r_ov ? r_oc : '0;
    assign o_match_confidence = r_ov ? r_of : '0;
    assign o_word_complete    = r_ov ? r_ocmp : 1'b0;
endmodule

/* sim/lpcf_checker.sv */
// Scoreboard for the lexicon prefix cohort filter: tracks config writes and
// accepted beats, predicts every result and compares it on the strobe.
// Depends on lpcf_pkg.
module lpcf_checker
    import lpcf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [1:0]          i_kind,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [POS_W-1:0]    i_symbol_position,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic [WORD_W-1:0]   i_word_ident,
    input  logic [LEN_W-1:0]    i_word_length,
    input  logic [CONF_W-1:0]   i_confidence,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_strobe,
    input  logic [WORD_W-1:0]   i_match_word,
    input  logic [LEN_W-1:0]    i_matched_count,
    input  logic [CONF_W-1:0]   i_match_confidence,
    input  logic                i_word_complete,
    input  logic                i_match_valid,
    input  logic                i_last_result,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_match_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  count;
        logic [CONF_W-1:0] conf;
        logic              complete;
        logic              valid;
        logic              last;
    } t_match;

    logic [WORD_W-1:0] lex_word [LEXICON_DEPTH];
    logic [LEN_W-1:0]  lex_len  [LEXICON_DEPTH];
    logic [SYM_W-1:0]  lex_sym  [LEXICON_DEPTH][MAX_WORD_SYMBOLS];
    logic [SYM_W-1:0]  heard    [MAX_WORD_SYMBOLS];
    int unsigned       heard_len;
    logic [CNT_W-1:0]  lex_count;
    logic [COH_W-1:0]  coh_limit;
    logic [LEN_W-1:0]  seq_limit;
    t_match            cohort_q[$];

    assign o_pending = cohort_q.size();

    function automatic t_match ack_beat();
        t_match m;
        m = '0;
        m.last = 1'b1;
        return m;
    endfunction

    task automatic predict_push(input logic [SYM_W-1:0] sym, input logic [CONF_W-1:0] conf);
        int unsigned cap, scan, lim, found;
        bit ok;
        t_match m;
        cap  = (seq_limit < MAX_WORD_SYMBOLS) ? seq_limit : MAX_WORD_SYMBOLS;
        scan = (lex_count < LEXICON_DEPTH) ? lex_count : LEXICON_DEPTH;
        lim  = (coh_limit < MAX_COHORT) ? coh_limit : MAX_COHORT;
        found = 0;
        if (heard_len < cap) begin
            heard[heard_len] = sym;
            heard_len++;
        end
        for (int w = 0; w < scan && found < lim; w++) begin
            ok = heard_len <= lex_len[w];
            for (int p = 0; ok && p < heard_len; p++)
                if (lex_sym[w][p] != heard[p]) ok = 0;
            if (ok) begin
                m.word     = lex_word[w];
                m.count    = heard_len[LEN_W-1:0];
                m.conf     = conf;
                m.complete = (heard_len == lex_len[w]);
                m.valid    = 1'b1;
                m.last     = 1'b0;
                cohort_q.push_back(m);
                found++;
            end
        end
        if (found == 0) cohort_q.push_back(ack_beat());
        else cohort_q[cohort_q.size()-1].last = 1'b1;
    endtask

    task automatic compare_beat();
        t_match e;
        if (cohort_q.size() == 0) begin
            $error("result beat with nothing expected");
            o_fail_count++;
            return;
        end
        e = cohort_q.pop_front();
        if (i_match_word !== e.word) begin
            $error("match_word exp %h got %h", e.word, i_match_word); o_fail_count++;
        end
        if (i_matched_count !== e.count) begin
            $error("matched_count exp %0d got %0d", e.count, i_matched_count); o_fail_count++;
        end
        if (i_match_confidence !== e.conf) begin
            $error("match_confidence exp %h got %h", e.conf, i_match_confidence);
            o_fail_count++;
        end
        if (i_word_complete !== e.complete) begin
            $error("word_complete exp %b got %b", e.complete, i_word_complete); o_fail_count++;
        end
        if (i_match_valid !== e.valid) begin
            $error("match_valid exp %b got %b", e.valid, i_match_valid); o_fail_count++;
        end
        if (i_last_result !== e.last) begin
            $error("last_result exp %b got %b", e.last, i_last_result); o_fail_count++;
        end
        if (e.valid) o_match_beats++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count  = 0;
            o_match_beats = 0;
            heard_len = 0;
            lex_count = '0;
            coh_limit = COH_W'(MAX_COHORT);
            seq_limit = LEN_W'(MAX_WORD_SYMBOLS);
            cohort_q.delete();
        end else begin
            if (i_strobe) compare_beat();
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_index))
                    R_LEXICON_COUNT:  lex_count = i_cfg_data;
                    R_COHORT_LIMIT:   coh_limit = i_cfg_data[COH_W-1:0];
                    R_SEQUENCE_LIMIT: seq_limit = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                case (t_kind'(i_kind))
                    K_HEADER: begin
                        lex_word[i_entry_index] = i_word_ident;
                        lex_len[i_entry_index]  = i_word_length;
                        cohort_q.push_back(ack_beat());
                    end
                    K_SYMBOL: begin
                        lex_sym[i_entry_index][i_symbol_position] = i_symbol;
                        cohort_q.push_back(ack_beat());
                    end
                    K_CLEAR: begin
                        heard_len = 0;
                        cohort_q.push_back(ack_beat());
                    end
                    default: predict_push(i_symbol, i_confidence);
                endcase
            end
        end
    end
endmodule

/* sim/tb_lexicon_prefix_cohort_filter.sv */
// Stimulus and verdict for the lexicon prefix cohort filter: loads a small
// lexicon, then runs pushes, loads and clears across several register settings.
// Depends on lpcf_pkg, lexicon_prefix_cohort_filter and lpcf_checker.
module tb_lexicon_prefix_cohort_filter;
    import lpcf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int NUM_LOAD    = 6;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic                o_busy;
    logic [1:0]          i_kind = '0;
    logic [IDX_W-1:0]    i_entry_index = '0;
    logic [POS_W-1:0]    i_symbol_position = '0;
    logic [SYM_W-1:0]    i_symbol = '0;
    logic [WORD_W-1:0]   i_word_ident = '0;
    logic [LEN_W-1:0]    i_word_length = '0;
    logic [CONF_W-1:0]   i_confidence = '0;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                o_strobe;
    logic [WORD_W-1:0]   o_match_word;
    logic [LEN_W-1:0]    o_matched_count;
    logic [CONF_W-1:0]   o_match_confidence;
    logic                o_word_complete;
    logic                o_match_valid;
    logic                o_last_result;
    int                  fail_count, pending, match_beats;

    logic [SYM_W-1:0]    shadow_sym [LEXICON_DEPTH][MAX_WORD_SYMBOLS];
    int unsigned         shadow_hl, cur_seq, beats_sent, idle_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lexicon_prefix_cohort_filter i_dut (.*);

    lpcf_checker i_chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_kind, .i_entry_index,
        .i_symbol_position, .i_symbol, .i_word_ident, .i_word_length, .i_confidence,
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_strobe(o_strobe),
        .i_match_word(o_match_word), .i_matched_count(o_matched_count),
        .i_match_confidence(o_match_confidence), .i_word_complete(o_word_complete),
        .i_match_valid(o_match_valid), .i_last_result(o_last_result),
        .o_fail_count(fail_count), .o_pending(pending), .o_match_beats(match_beats)
    );

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe || i_cfg_we || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_beat(input t_kind kind, input int unsigned idx, input int unsigned pos,
                             input int unsigned sym, input logic [WORD_W-1:0] ident,
                             input int unsigned wlen, input logic [CONF_W-1:0] conf,
                             input int unsigned gap);
        bit taken;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start           <= 1'b1;
        i_kind            <= kind;
        i_entry_index     <= idx[IDX_W-1:0];
        i_symbol_position <= pos[POS_W-1:0];
        i_symbol          <= sym[SYM_W-1:0];
        i_word_ident      <= ident;
        i_word_length     <= wlen[LEN_W-1:0];
        i_confidence      <= conf;
        do begin
            @(negedge i_clk);
            taken = !o_busy;
            @(posedge i_clk);
        end while (!taken);
        beats_sent++;
        if (kind == K_SYMBOL) shadow_sym[idx][pos] = sym[SYM_W-1:0];
        if (kind == K_CLEAR) shadow_hl = 0;
        if (kind == K_PUSH && shadow_hl < cur_seq && shadow_hl < MAX_WORD_SYMBOLS)
            shadow_hl++;
    endtask

    task automatic drain();
        i_start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_reg idx, input int unsigned data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == R_SEQUENCE_LIMIT) cur_seq = data;
    endtask

    function automatic int unsigned pick_sym();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
    endfunction

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic random_beats(input int n);
        int unsigned r, e;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            e = $urandom_range(0, NUM_LOAD - 1);
            if (r < 12)
                send_beat(K_HEADER, e, 0, 0, $urandom(),
                          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, 16),
                          '0, pick_gap());
            else if (r < 24)
                send_beat(K_SYMBOL, e, $urandom_range(0, 15), pick_sym(), $urandom(),
                          $urandom_range(0, 31), $urandom(), pick_gap());
            else if (r < 32)
                send_beat(K_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 15),
                          $urandom_range(0, 255), $urandom(), $urandom_range(0, 31),
                          $urandom(), pick_gap());
            else if (r < 88 && shadow_hl < MAX_WORD_SYMBOLS)
                send_beat(K_PUSH, $urandom_range(0, 1023), $urandom_range(0, 15),
                          shadow_sym[e][shadow_hl], $urandom(), $urandom_range(0, 31),
                          $urandom(), pick_gap());
            else
                send_beat(K_PUSH, $urandom_range(0, 1023), $urandom_range(0, 15),
                          $urandom_range(0, 255), $urandom(), $urandom_range(0, 31),
                          $urandom(), pick_gap());
        end
    endtask

    initial begin
        shadow_hl  = 0;
        cur_seq    = 16;
        beats_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty lexicon: push gives an empty cohort, then clear
        send_beat(K_PUSH, 0, 0, 8'hFF, '1, 0, 16'hFFFF, 0);
        send_beat(K_CLEAR, 1023, 15, 0, '0, 31, '0, 2);

        // load the first entries back to back; the lowest hold directed words
        for (int e = 0; e < NUM_LOAD; e++) begin
            int unsigned wl;
            logic [WORD_W-1:0] id;
            bit wide;
            wide = ($urandom_range(0, 3) == 0);
            case (e)
                0: begin wl = 16; id = '1; end
                1: begin wl = 31; id = 32'h0000_0001; end
                2: begin wl = 0;  id = 32'h8000_0000; end
                3: begin wl = 2;  id = '0; end
                default: begin
                    wl = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
                                                     : $urandom_range(0, 16);
                    id = $urandom();
                end
            endcase
            send_beat(K_HEADER, e, 0, 0, id, wl, '0, 0);
            for (int p = 0; p < MAX_WORD_SYMBOLS; p++)
                send_beat(K_SYMBOL, e, p,
                          (e < 4) ? ((e == 0) ? 255 : 0)
                                  : (wide ? $urandom_range(0, 255) : $urandom_range(0, 3)),
                          '0, 0, '0, 0);
        end
        drain();

        // full scan of the loaded entries; full sequence drops symbols
        cfg_write(R_LEXICON_COUNT, NUM_LOAD);
        send_beat(K_PUSH, 0, 0, 0, '0, 0, 16'h0000, 0);
        send_beat(K_PUSH, 0, 0, 0, '0, 0, 16'hFFFF, 3);
        send_beat(K_CLEAR, 0, 0, 0, '0, 0, '0, 0);
        for (int i = 0; i < 17; i++) send_beat(K_PUSH, 0, 0, 255, '0, 0, $urandom(), 0);
        send_beat(K_CLEAR, 0, 0, 0, '0, 0, '0, 0);
        random_beats(15);
        drain();

        // out-of-range limits clamp; unused index is ignored
        cfg_write(R_COHORT_LIMIT, 127);
        cfg_write(R_SEQUENCE_LIMIT, 31);
        cfg_write(R_UNUSED, 2047);
        random_beats(15);
        drain();

        cfg_write(R_COHORT_LIMIT, 1);
        cfg_write(R_SEQUENCE_LIMIT, 16);
        random_beats(20);
        drain();

        // cohort limit zero reports nothing
        cfg_write(R_COHORT_LIMIT, 0);
        cfg_write(R_SEQUENCE_LIMIT, 4);
        random_beats(15);
        drain();

        cfg_write(R_COHORT_LIMIT, 3);
        cfg_write(R_SEQUENCE_LIMIT, 16);
        send_beat(K_CLEAR, 0, 0, 0, '0, 0, '0, 0);
        send_beat(K_PUSH, 0, 0, shadow_sym[5][0], '0, 0, $urandom(), 0);
        send_beat(K_PUSH, 0, 0, shadow_sym[5][1], '0, 0, $urandom(), 0);
        random_beats(15);
        drain();

        // lower the sequence limit below the held length, no clear
        cfg_write(R_COHORT_LIMIT, 64);
        cfg_write(R_SEQUENCE_LIMIT, 1);
        random_beats(15);
        drain();

        // oversized entry count clamps; empty sequence stops on the first entry
        cfg_write(R_LEXICON_COUNT, 2047);
        cfg_write(R_COHORT_LIMIT, 1);
        cfg_write(R_SEQUENCE_LIMIT, 0);
        send_beat(K_CLEAR, 0, 0, 0, '0, 0, '0, 0);
        random_beats(10);
        drain();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d beats over eight register settings; %0d match beats checked.",
                 beats_sent, match_beats);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/lpcf_pkg.sv
rtl/lpcf_front.sv
rtl/lpcf_back.sv
rtl/lexicon_prefix_cohort_filter.sv
sim/lpcf_checker.sv
sim/tb_lexicon_prefix_cohort_filter.sv
